[sv/mcwoc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mcwoc_pkg;

    localparam int SECS_W = 44;
    localparam int NS_W = 30;
    localparam int SECS_SPLIT = 22;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_GET  = 2'd1;
    localparam logic [1:0] ACT_SET  = 2'd2;

    localparam logic [19:0] US_PER_SEC = 20'd1000000;
    localparam logic [9:0]  NS_PER_US  = 10'd1000;

    // The divide by one million runs on 12-bit digits with a reciprocal multiply.
    localparam int          US_DIGIT_W     = 12;
    localparam int          US_DIGITS      = 6;
    localparam int          US_RECIP_SHIFT = 51;
    localparam logic [31:0] US_RECIP       = 32'd2251799814;

    // Nanoseconds to microseconds by a reciprocal multiply.
    localparam int          NS_RECIP_SHIFT = 38;
    localparam logic [28:0] NS_RECIP       = 29'd274877907;
    localparam int          US_OF_NS_W     = 21;

    typedef struct packed {
        logic [1:0]        op;
        logic [SECS_W-1:0] secs;
        logic [NS_W-1:0]   nsecs;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [6:0]  steps;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic [63:0] quot;
        logic [32:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

[sv/microsecond_clock_with_overflow_count.sv]
// A tick takes effect when the back end pops it from the command queue. A get
// runs S_G0 to S_G2, six digit rounds of S_GQ and S_GR for the divide by one
// million, and S_GOUT; a set runs S_S0 to S_S2 and S_SDIV for the 64-step divide
// by period+1. Ticks are taken one per cycle while no get or set is in progress.
// A get stalls while the previous result is not taken.
// Reset: rst_n clears the counter, overflow count and queue and loads period 65535.
`timescale 1ns / 1ps
`default_nettype none

module microsecond_clock_with_overflow_count
    import mcwoc_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [31:0]       cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire logic [SECS_W-1:0] set_seconds,
    input  wire logic [NS_W-1:0]   set_nanoseconds,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SECS_W-1:0]      seconds,
    output logic [NS_W-1:0]        nanoseconds
);

    logic [31:0] period_reg;
    logic        q_valid;
    cmd_t        q_cmd;
    logic        q_pop;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 32'd65535;
        end
        else if (cfg_write_en)
        begin
            period_reg <= cfg_write_data;
        end
    end

    mcwoc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .set_seconds     (set_seconds),
        .set_nanoseconds (set_nanoseconds),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop)
    );

    mcwoc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mcwoc_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .period      (period_reg),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .seconds     (seconds),
        .nanoseconds (nanoseconds)
    );

endmodule

`default_nettype wire

[sv/mcwoc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mcwoc_front
    import mcwoc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire logic [SECS_W-1:0] set_seconds,
    input  wire logic [NS_W-1:0]   set_nanoseconds,
    output logic                   q_valid,
    output cmd_t                   q_cmd,
    input  wire logic              q_pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       known;
    logic       push;

    always_comb
    begin
        unique case (action) inside
            ACT_TICK, ACT_GET, ACT_SET: known = 1'b1;
            default:                    known = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && known;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{op: action, secs: set_seconds, nsecs: set_nanoseconds};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("Pop from an empty command queue.");

endmodule

`default_nettype wire

[sv/mcwoc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module mcwoc_div
    import mcwoc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [63:0] dvd_reg;
    logic [63:0] quot_reg;
    logic [32:0] rem_reg;
    logic [6:0]  steps_reg;
    logic        busy_reg;
    logic [33:0] trial;
    logic        ge;

    assign trial = {rem_reg, dvd_reg[63]};
    assign ge    = (trial >= {1'b0, req.divisor});

    assign rsp.busy = busy_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            steps_reg <= 7'd0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            steps_reg <= req.steps;
        end
        else if (busy_reg)
        begin
            steps_reg <= steps_reg - 7'd1;
            if (steps_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg  <= req.dividend;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[62:0], 1'b0};
            quot_reg <= {quot_reg[62:0], ge};
            rem_reg  <= ge ? 33'(trial - {1'b0, req.divisor}) : trial[32:0];
        end
    end

endmodule

`default_nettype wire

[sv/mcwoc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mcwoc_back
    import mcwoc_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [31:0]       period,
    input  wire logic              q_valid,
    input  wire cmd_t              q_cmd,
    output logic                   q_pop,
    output div_req_t               div_req,
    input  wire div_rsp_t          div_rsp,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SECS_W-1:0]      seconds,
    output logic [NS_W-1:0]        nanoseconds
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_G0   = 4'd1;
    localparam logic [3:0] S_G1   = 4'd2;
    localparam logic [3:0] S_G2   = 4'd3;
    localparam logic [3:0] S_GQ   = 4'd4;
    localparam logic [3:0] S_GR   = 4'd5;
    localparam logic [3:0] S_GOUT = 4'd6;
    localparam logic [3:0] S_S0   = 4'd7;
    localparam logic [3:0] S_S1   = 4'd8;
    localparam logic [3:0] S_S2   = 4'd9;
    localparam logic [3:0] S_SDIV = 4'd10;

    logic [3:0]               state_reg, state_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg, cnt_next;
    logic [63:0]              ovf_reg, ovf_next;
    logic [63:0]              acc_reg, acc_next;
    logic [63:0]              prod_reg, prod_next;
    logic [SECS_W-1:0]        secs_reg, secs_next;
    logic [NS_W-1:0]          nsin_reg, nsin_next;
    logic [71:0]              num_reg, num_next;
    logic [19:0]              urem_reg, urem_next;
    logic [47:0]              uquot_reg, uquot_next;
    logic [2:0]               digit_reg, digit_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SECS_W-1:0]        seconds_reg, seconds_next;
    logic [NS_W-1:0]          nanoseconds_reg, nanoseconds_next;
    logic [COUNTER_WIDTH-1:0] eff;
    logic [31:0]              eff32;
    logic [32:0]              d33;
    logic [31:0]              ux;
    logic [US_DIGIT_W-1:0]    qd;

    assign eff   = period[COUNTER_WIDTH-1:0];
    assign eff32 = 32'(eff);
    assign d33   = 33'(eff) + 33'd1;

    // Partial dividend of one digit round and its quotient digit.
    assign ux = {urem_reg, num_reg[71:72-US_DIGIT_W]};
    assign qd = prod_reg[US_RECIP_SHIFT+US_DIGIT_W-1:US_RECIP_SHIFT];

    assign out_valid   = out_valid_reg;
    assign seconds     = seconds_reg;
    assign nanoseconds = nanoseconds_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        ovf_next         = ovf_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        secs_next        = secs_reg;
        nsin_next        = nsin_reg;
        num_next         = num_reg;
        urem_next        = urem_reg;
        uquot_next       = uquot_reg;
        digit_next       = digit_reg;
        seconds_next     = seconds_reg;
        nanoseconds_next = nanoseconds_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.steps    = 7'd64;
        div_req.dividend = acc_reg;
        div_req.divisor  = d33;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    secs_next = q_cmd.secs;
                    nsin_next = q_cmd.nsecs;
                    unique case (q_cmd.op)
                        ACT_GET: state_next = S_G0;
                        ACT_SET: state_next = S_S0;
                        default:
                        begin
                            if (cnt_reg >= eff)
                            begin
                                cnt_next = '0;
                                ovf_next = ovf_reg + 64'd1;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + COUNTER_WIDTH'(1);
                            end
                        end
                    endcase
                end
            end
            S_G0:
            begin
                prod_next  = 64'(ovf_reg[31:0]) * 64'(eff32);
                acc_next   = ovf_reg + 64'(cnt_reg);
                state_next = S_G1;
            end
            S_G1:
            begin
                acc_next   = acc_reg + prod_reg;
                prod_next  = 64'(ovf_reg[63:32]) * 64'(eff32);
                state_next = S_G2;
            end
            S_G2:
            begin
                num_next   = {8'd0, acc_reg + {prod_reg[31:0], 32'b0}};
                urem_next  = '0;
                digit_next = '0;
                state_next = S_GQ;
            end
            S_GQ:
            begin
                prod_next  = 64'(ux) * 64'(US_RECIP);
                state_next = S_GR;
            end
            S_GR:
            begin
                urem_next  = 20'(ux - 32'(qd) * 32'(US_PER_SEC));
                uquot_next = {uquot_reg[47-US_DIGIT_W:0], qd};
                num_next   = {num_reg[71-US_DIGIT_W:0], US_DIGIT_W'(0)};
                digit_next = digit_reg + 3'd1;
                if (digit_reg == 3'(US_DIGITS - 1))
                begin
                    state_next = S_GOUT;
                end
                else
                begin
                    state_next = S_GQ;
                end
            end
            S_GOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    seconds_next     = uquot_reg[SECS_W-1:0];
                    nanoseconds_next = NS_W'(30'(urem_reg) * 30'(NS_PER_US));
                    state_next       = S_IDLE;
                end
            end
            S_S0:
            begin
                prod_next  = 64'(secs_reg[SECS_SPLIT-1:0]) * 64'(US_PER_SEC);
                acc_next   = 64'(nsin_reg) * 64'(NS_RECIP);
                state_next = S_S1;
            end
            S_S1:
            begin
                acc_next   = prod_reg
                           + 64'(acc_reg[NS_RECIP_SHIFT+US_OF_NS_W-1:NS_RECIP_SHIFT]);
                prod_next  = 64'(secs_reg[SECS_W-1:SECS_SPLIT]) * 64'(US_PER_SEC);
                state_next = S_S2;
            end
            S_S2:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_reg + {prod_reg[63-SECS_SPLIT:0], SECS_SPLIT'(0)};
                state_next       = S_SDIV;
            end
            S_SDIV:
            begin
                if (!div_rsp.busy)
                begin
                    ovf_next   = div_rsp.quot;
                    cnt_next   = div_rsp.rem[COUNTER_WIDTH-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        secs_reg        <= secs_next;
        nsin_reg        <= nsin_next;
        num_reg         <= num_next;
        urem_reg        <= urem_next;
        uquot_reg       <= uquot_next;
        digit_reg       <= digit_next;
        seconds_reg     <= seconds_next;
        nanoseconds_reg <= nanoseconds_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
        else $error("Divider started while still busy.");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> (state_reg == S_IDLE))
        else $error("Command taken while an operation is in progress.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GOUT && out_valid_reg && !out_ready) |=> (state_reg == S_GOUT))
        else $error("Result dropped while the output register was full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && q_valid && q_cmd.op == ACT_TICK) |=>
        (cnt_reg == '0 || cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("Tick moved the counter by other than one step.");

endmodule

`default_nettype wire
